[rtl/kle_pkg.sv]
// ----------------------------------------------------------------------------
// kle_pkg
// Shared types, constants and key translation for the key event line editor.
// ----------------------------------------------------------------------------
package kle_pkg;

  localparam int KLE_CAPACITY = 64;
  localparam int PC_W         = 5;

  // Virtual key codes that the editor decodes.
  localparam logic [6:0] KEY_BACKSPACE  = 7'd8;
  localparam logic [6:0] KEY_ENTER      = 7'd13;
  localparam logic [6:0] KEY_SHIFT      = 7'd16;
  localparam logic [6:0] KEY_CTRL       = 7'd17;
  localparam logic [6:0] KEY_CAPS       = 7'd20;
  localparam logic [6:0] KEY_ESC        = 7'd27;
  localparam logic [6:0] KEY_END        = 7'd35;
  localparam logic [6:0] KEY_HOME       = 7'd36;
  localparam logic [6:0] KEY_LEFT       = 7'd37;
  localparam logic [6:0] KEY_ARROW_UP   = 7'd38;
  localparam logic [6:0] KEY_RIGHT      = 7'd39;
  localparam logic [6:0] KEY_ARROW_DOWN = 7'd40;
  localparam logic [6:0] KEY_DELETE     = 7'd46;
  localparam logic [6:0] KEY_DEL_CHAR   = 7'd127;
  localparam logic [7:0] KEY_SHIFT_DN   = 8'd16;
  localparam logic [7:0] KEY_CAPS_DN    = 8'd20;

  // Result kinds.
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_CHAR   = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  // Microprogram entry points and targets.
  localparam logic [PC_W-1:0] UA_STATUS    = 5'd0;
  localparam logic [PC_W-1:0] UA_ESC       = 5'd1;
  localparam logic [PC_W-1:0] UA_LEFT      = 5'd2;
  localparam logic [PC_W-1:0] UA_RIGHT     = 5'd3;
  localparam logic [PC_W-1:0] UA_HOME      = 5'd4;
  localparam logic [PC_W-1:0] UA_END       = 5'd5;
  localparam logic [PC_W-1:0] UA_INS       = 5'd6;
  localparam logic [PC_W-1:0] UA_INS_LOOP  = 5'd7;
  localparam logic [PC_W-1:0] UA_INS_MOVE  = 5'd8;
  localparam logic [PC_W-1:0] UA_INS_REJ   = 5'd9;
  localparam logic [PC_W-1:0] UA_INS_PUT   = 5'd10;
  localparam logic [PC_W-1:0] UA_BS        = 5'd11;
  localparam logic [PC_W-1:0] UA_BS_LOOP   = 5'd12;
  localparam logic [PC_W-1:0] UA_BS_MOVE   = 5'd13;
  localparam logic [PC_W-1:0] UA_BS_DONE   = 5'd14;
  localparam logic [PC_W-1:0] UA_DEL       = 5'd15;
  localparam logic [PC_W-1:0] UA_DEL_LOOP  = 5'd16;
  localparam logic [PC_W-1:0] UA_DEL_MOVE  = 5'd17;
  localparam logic [PC_W-1:0] UA_DEL_DONE  = 5'd18;
  localparam logic [PC_W-1:0] UA_ENT       = 5'd19;
  localparam logic [PC_W-1:0] UA_ENT_READ  = 5'd20;
  localparam logic [PC_W-1:0] UA_ENT_EMIT  = 5'd21;
  localparam logic [PC_W-1:0] UA_ENT_CLEAR = 5'd22;
  localparam logic [PC_W-1:0] UA_ENT_EMPTY = 5'd23;

  typedef enum logic [2:0] {
    PTR_HOLD, PTR_CUR, PTR_CUR_P1, PTR_LEN, PTR_ZERO, PTR_INC, PTR_DEC
  } ptr_op_t;

  typedef enum logic [1:0] {
    RD_NONE, RD_PTR, RD_PTR_M1
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE, WR_PTR, WR_PTR_M1, WR_CHAR
  } wr_sel_t;

  typedef enum logic [2:0] {
    CUR_HOLD, CUR_ZERO, CUR_INC, CUR_DEC, CUR_DEC_SAT, CUR_INC_SAT, CUR_LEN
  } cur_op_t;

  typedef enum logic [1:0] {
    LEN_HOLD, LEN_ZERO, LEN_INC, LEN_DEC
  } len_op_t;

  typedef enum logic [1:0] {
    EM_NONE, EM_STATUS, EM_CHAR, EM_EMPTY
  } emit_t;

  typedef enum logic [3:0] {
    C_NONE, C_ALWAYS, C_LEN_FULL, C_PTR_LE_CUR, C_CUR_ZERO, C_PTR_GE_LEN,
    C_CUR_GE_LEN, C_LEN_ZERO, C_PTR_NOT_LAST
  } cond_t;

  // One control word of the microprogram.
  typedef struct packed {
    ptr_op_t         ptr_op;
    rd_sel_t         rd;
    wr_sel_t         wr;
    cur_op_t         cur_op;
    len_op_t         len_op;
    emit_t           emit;
    logic            set_rej;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            fin;
  } kle_cw_t;

  // Datapath flags tested by conditional jumps.
  typedef struct packed {
    logic len_full;
    logic ptr_le_cur;
    logic cur_zero;
    logic ptr_ge_len;
    logic cur_ge_len;
    logic len_zero;
    logic ptr_not_last;
  } kle_flags_t;

  function automatic logic [6:0] kle_sym_plain(input logic [6:0] k);
    logic [6:0] r;
    case (k)
      7'd58:   r = 7'h3B; // ;
      7'd59:   r = 7'h3D; // =
      7'd60:   r = 7'h2C; // ,
      7'd61:   r = 7'h2D; // -
      7'd62:   r = 7'h2E; // .
      7'd63:   r = 7'h2F; // /
      default: r = 7'h60; // `
    endcase
    return r;
  endfunction

  function automatic logic [6:0] kle_sym_shift(input logic [6:0] k);
    logic [6:0] r;
    case (k)
      7'd58:   r = 7'h3A; // :
      7'd59:   r = 7'h2B; // +
      7'd60:   r = 7'h3C; // <
      7'd61:   r = 7'h5F; // _
      7'd62:   r = 7'h3E; // >
      7'd63:   r = 7'h3F; // ?
      default: r = 7'h7E; // ~
    endcase
    return r;
  endfunction

  function automatic logic [6:0] kle_digit_shift(input logic [6:0] k);
    logic [6:0] r;
    case (k)
      7'd48:   r = 7'h29; // )
      7'd49:   r = 7'h21; // !
      7'd50:   r = 7'h40; // @
      7'd51:   r = 7'h23; // #
      7'd52:   r = 7'h24; // $
      7'd53:   r = 7'h25; // %
      7'd54:   r = 7'h5E; // ^
      7'd55:   r = 7'h26; // &
      7'd56:   r = 7'h2A; // *
      default: r = 7'h28; // (
    endcase
    return r;
  endfunction

  function automatic logic [6:0] kle_brace_shift(input logic [6:0] k);
    logic [6:0] r;
    case (k)
      7'd91:   r = 7'h7B; // {
      7'd92:   r = 7'h7C; // |
      default: r = 7'h7D; // }
    endcase
    return r;
  endfunction

  // The mapped ranges never overlap, so a single priority chain suffices.
  function automatic logic [6:0] kle_translate(input logic [6:0] k, input logic shift,
                                               input logic caps);
    logic [6:0] r;
    r = k;
    if (k >= 7'd58 && k <= 7'd64) begin
      r = shift ? kle_sym_shift(k) : kle_sym_plain(k);
    end else if (k == 7'd94) begin
      r = shift ? 7'h22 : 7'h27;
    end else if (shift && k >= 7'd91 && k <= 7'd93) begin
      r = kle_brace_shift(k);
    end else if (shift && k >= 7'd48 && k <= 7'd57) begin
      r = kle_digit_shift(k);
    end else if (k >= 7'd65 && k <= 7'd90 && !shift && !caps) begin
      r = k + 7'd32;
    end
    return r;
  endfunction

endpackage

[rtl/kle_ucode_rom.sv]
// ----------------------------------------------------------------------------
// kle_ucode_rom
// Read-only microprogram: one control word for each step address.
// ----------------------------------------------------------------------------
module kle_ucode_rom (
  input  logic [kle_pkg::PC_W-1:0] pc,
  output kle_pkg::kle_cw_t         cw
);
  import kle_pkg::*;

  always_comb begin
    cw = '0;
    case (pc)
      UA_STATUS: begin
        cw.emit = EM_STATUS;
        cw.fin  = 1'b1;
      end
      UA_ESC: begin
        cw.cur_op = CUR_ZERO;
        cw.len_op = LEN_ZERO;
        cw.cond   = C_ALWAYS;
        cw.target = UA_STATUS;
      end
      UA_LEFT: begin
        cw.cur_op = CUR_DEC_SAT;
        cw.cond   = C_ALWAYS;
        cw.target = UA_STATUS;
      end
      UA_RIGHT: begin
        cw.cur_op = CUR_INC_SAT;
        cw.cond   = C_ALWAYS;
        cw.target = UA_STATUS;
      end
      UA_HOME: begin
        cw.cur_op = CUR_ZERO;
        cw.cond   = C_ALWAYS;
        cw.target = UA_STATUS;
      end
      UA_END: begin
        cw.cur_op = CUR_LEN;
        cw.cond   = C_ALWAYS;
        cw.target = UA_STATUS;
      end
      // Insert: open a gap at the cursor by moving the tail up from the end.
      UA_INS: begin
        cw.ptr_op = PTR_LEN;
        cw.cond   = C_LEN_FULL;
        cw.target = UA_INS_REJ;
      end
      UA_INS_LOOP: begin
        cw.rd     = RD_PTR_M1;
        cw.cond   = C_PTR_LE_CUR;
        cw.target = UA_INS_PUT;
      end
      UA_INS_MOVE: begin
        cw.wr     = WR_PTR;
        cw.ptr_op = PTR_DEC;
        cw.cond   = C_ALWAYS;
        cw.target = UA_INS_LOOP;
      end
      UA_INS_REJ: begin
        cw.set_rej = 1'b1;
        cw.cond    = C_ALWAYS;
        cw.target  = UA_STATUS;
      end
      UA_INS_PUT: begin
        cw.wr     = WR_CHAR;
        cw.cur_op = CUR_INC;
        cw.len_op = LEN_INC;
        cw.cond   = C_ALWAYS;
        cw.target = UA_STATUS;
      end
      // Backspace: close the gap before the cursor, moving the tail down.
      UA_BS: begin
        cw.ptr_op = PTR_CUR;
        cw.cond   = C_CUR_ZERO;
        cw.target = UA_STATUS;
      end
      UA_BS_LOOP: begin
        cw.rd     = RD_PTR;
        cw.cond   = C_PTR_GE_LEN;
        cw.target = UA_BS_DONE;
      end
      UA_BS_MOVE: begin
        cw.wr     = WR_PTR_M1;
        cw.ptr_op = PTR_INC;
        cw.cond   = C_ALWAYS;
        cw.target = UA_BS_LOOP;
      end
      UA_BS_DONE: begin
        cw.cur_op = CUR_DEC;
        cw.len_op = LEN_DEC;
        cw.cond   = C_ALWAYS;
        cw.target = UA_STATUS;
      end
      // Delete: close the gap at the cursor.
      UA_DEL: begin
        cw.ptr_op = PTR_CUR_P1;
        cw.cond   = C_CUR_GE_LEN;
        cw.target = UA_STATUS;
      end
      UA_DEL_LOOP: begin
        cw.rd     = RD_PTR;
        cw.cond   = C_PTR_GE_LEN;
        cw.target = UA_DEL_DONE;
      end
      UA_DEL_MOVE: begin
        cw.wr     = WR_PTR_M1;
        cw.ptr_op = PTR_INC;
        cw.cond   = C_ALWAYS;
        cw.target = UA_DEL_LOOP;
      end
      UA_DEL_DONE: begin
        cw.len_op = LEN_DEC;
        cw.cond   = C_ALWAYS;
        cw.target = UA_STATUS;
      end
      // Enter: the length is kept until the walk ends, to bound it.
      UA_ENT: begin
        cw.ptr_op = PTR_ZERO;
        cw.cur_op = CUR_ZERO;
        cw.cond   = C_LEN_ZERO;
        cw.target = UA_ENT_EMPTY;
      end
      UA_ENT_READ: begin
        cw.rd = RD_PTR;
      end
      UA_ENT_EMIT: begin
        cw.emit   = EM_CHAR;
        cw.ptr_op = PTR_INC;
        cw.cond   = C_PTR_NOT_LAST;
        cw.target = UA_ENT_READ;
      end
      UA_ENT_CLEAR: begin
        cw.len_op = LEN_ZERO;
        cw.fin    = 1'b1;
      end
      UA_ENT_EMPTY: begin
        cw.emit = EM_EMPTY;
        cw.fin  = 1'b1;
      end
      default: begin
        cw.fin = 1'b1;
      end
    endcase
  end

endmodule

[rtl/kle_seq.sv]
// ----------------------------------------------------------------------------
// kle_seq
// Step counter: dispatches each item to its microprogram and follows jumps.
// ----------------------------------------------------------------------------
module kle_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [6:0]         key_code,
  input  logic               pressed,
  input  kle_pkg::kle_flags_t flags,
  output kle_pkg::kle_cw_t   cw,
  output logic               busy
);
  import kle_pkg::*;

  logic            run_r, run_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic [PC_W-1:0] entry;
  logic            take;
  kle_cw_t         rom_cw;

  kle_ucode_rom u_rom (
    .pc (pc_r),
    .cw (rom_cw)
  );

  // Outside a program the datapath sees an all-hold word.
  assign cw   = run_r ? rom_cw : '0;
  assign busy = run_r;

  always_comb begin
    entry = UA_INS;
    if (pressed) begin
      entry = UA_STATUS;
    end else begin
      case (key_code)
        KEY_ENTER:     entry = UA_ENT;
        KEY_ESC:       entry = UA_ESC;
        KEY_LEFT:      entry = UA_LEFT;
        KEY_RIGHT:     entry = UA_RIGHT;
        KEY_HOME:      entry = UA_HOME;
        KEY_END:       entry = UA_END;
        KEY_BACKSPACE: entry = UA_BS;
        KEY_DELETE:    entry = UA_DEL;
        KEY_SHIFT, KEY_CTRL, KEY_CAPS, KEY_ARROW_UP, KEY_ARROW_DOWN, KEY_DEL_CHAR: begin
          entry = UA_STATUS;
        end
        default:       entry = UA_INS;
      endcase
    end
  end

  always_comb begin
    case (cw.cond)
      C_NONE:         take = 1'b0;
      C_ALWAYS:       take = 1'b1;
      C_LEN_FULL:     take = flags.len_full;
      C_PTR_LE_CUR:   take = flags.ptr_le_cur;
      C_CUR_ZERO:     take = flags.cur_zero;
      C_PTR_GE_LEN:   take = flags.ptr_ge_len;
      C_CUR_GE_LEN:   take = flags.cur_ge_len;
      C_LEN_ZERO:     take = flags.len_zero;
      C_PTR_NOT_LAST: take = flags.ptr_not_last;
      default:        take = 1'b0;
    endcase
  end

  always_comb begin
    run_nxt = run_r;
    pc_nxt  = pc_r;
    if (accept) begin
      run_nxt = 1'b1;
      pc_nxt  = entry;
    end else if (run_r) begin
      if (cw.fin) begin
        run_nxt = 1'b0;
      end else if (take) begin
        pc_nxt = cw.target;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      pc_r  <= UA_STATUS;
    end else begin
      run_r <= run_nxt;
      pc_r  <= pc_nxt;
    end
  end

  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> run_r && pc_r == $past(entry))
    else $error("accepted item did not start its microprogram");

  a_fin_only: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(run_r) && $past(rst_n) |-> $past(cw.fin))
    else $error("sequencer stopped without a final step");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    run_r && !cw.fin |=> run_r)
    else $error("sequencer left a program before its final step");

endmodule

[rtl/kle_datapath.sv]
// ----------------------------------------------------------------------------
// kle_datapath
// Line store, cursor, length and walk pointer, driven by the control word.
// ----------------------------------------------------------------------------
module kle_datapath #(
  parameter int CAPACITY = kle_pkg::KLE_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          key_code,
  input  logic                pressed,
  input  kle_pkg::kle_cw_t    cw,
  output kle_pkg::kle_flags_t flags,
  output logic                out_valid,
  output logic [1:0]          out_kind,
  output logic [6:0]          out_char_out,
  output logic [6:0]          out_cursor,
  output logic [6:0]          out_length,
  output logic                out_rejected,
  output logic                out_last
);
  import kle_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [6:0]    line_mem [CAPACITY];
  logic [6:0]    rdata_r;

  logic [CW-1:0] cursor_r, cursor_nxt;
  logic [CW-1:0] length_r, length_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] ptr_m1, ptr_p1;
  logic          shift_r, shift_nxt;
  logic          caps_r, caps_nxt;
  logic          rej_r, rej_nxt;
  logic [6:0]    char_r;

  logic [AW-1:0] raddr, waddr;
  logic          we;
  logic [6:0]    wdata;

  logic          out_valid_r;
  logic [1:0]    out_kind_r;
  logic [6:0]    out_char_r, out_cursor_r, out_length_r;
  logic          out_rej_r, out_last_r;

  assign ptr_m1 = ptr_r - 1'b1;
  assign ptr_p1 = ptr_r + 1'b1;

  always_comb begin
    flags.len_full     = (length_r == CAP_C);
    flags.ptr_le_cur   = (ptr_r <= cursor_r);
    flags.cur_zero     = (cursor_r == '0);
    flags.ptr_ge_len   = (ptr_r >= length_r);
    flags.cur_ge_len   = (cursor_r >= length_r);
    flags.len_zero     = (length_r == '0);
    flags.ptr_not_last = (ptr_p1 != length_r);
  end

  // Key flags and the translated character are taken when the item is accepted.
  always_comb begin
    shift_nxt = shift_r;
    caps_nxt  = caps_r;
    rej_nxt   = rej_r;
    if (accept) begin
      rej_nxt = 1'b0;
      if (pressed) begin
        if (key_code == KEY_SHIFT_DN) shift_nxt = 1'b1;
        if (key_code == KEY_CAPS_DN)  caps_nxt  = !caps_r;
      end else if (key_code[6:0] == KEY_SHIFT) begin
        shift_nxt = 1'b0;
      end
    end else if (cw.set_rej) begin
      rej_nxt = 1'b1;
    end
  end

  always_comb begin
    case (cw.ptr_op)
      PTR_HOLD:   ptr_nxt = ptr_r;
      PTR_CUR:    ptr_nxt = cursor_r;
      PTR_CUR_P1: ptr_nxt = cursor_r + 1'b1;
      PTR_LEN:    ptr_nxt = length_r;
      PTR_ZERO:   ptr_nxt = '0;
      PTR_INC:    ptr_nxt = ptr_p1;
      PTR_DEC:    ptr_nxt = ptr_m1;
      default:    ptr_nxt = ptr_r;
    endcase
  end

  always_comb begin
    case (cw.cur_op)
      CUR_HOLD:    cursor_nxt = cursor_r;
      CUR_ZERO:    cursor_nxt = '0;
      CUR_INC:     cursor_nxt = cursor_r + 1'b1;
      CUR_DEC:     cursor_nxt = cursor_r - 1'b1;
      CUR_DEC_SAT: cursor_nxt = (cursor_r != '0) ? cursor_r - 1'b1 : cursor_r;
      CUR_INC_SAT: cursor_nxt = (cursor_r < length_r) ? cursor_r + 1'b1 : cursor_r;
      CUR_LEN:     cursor_nxt = length_r;
      default:     cursor_nxt = cursor_r;
    endcase
  end

  always_comb begin
    case (cw.len_op)
      LEN_HOLD: length_nxt = length_r;
      LEN_ZERO: length_nxt = '0;
      LEN_INC:  length_nxt = length_r + 1'b1;
      LEN_DEC:  length_nxt = length_r - 1'b1;
      default:  length_nxt = length_r;
    endcase
  end

  always_comb begin
    raddr = (cw.rd == RD_PTR_M1) ? ptr_m1[AW-1:0] : ptr_r[AW-1:0];
    we    = (cw.wr != WR_NONE);
    wdata = rdata_r;
    case (cw.wr)
      WR_PTR:    waddr = ptr_r[AW-1:0];
      WR_PTR_M1: waddr = ptr_m1[AW-1:0];
      WR_CHAR: begin
        waddr = cursor_r[AW-1:0];
        wdata = char_r;
      end
      default:   waddr = ptr_r[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cw.rd != RD_NONE) rdata_r <= line_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (we) line_mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= '0;
      length_r    <= '0;
      shift_r     <= 1'b0;
      caps_r      <= 1'b0;
      rej_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cursor_r    <= cursor_nxt;
      length_r    <= length_nxt;
      shift_r     <= shift_nxt;
      caps_r      <= caps_nxt;
      rej_r       <= rej_nxt;
      out_valid_r <= (cw.emit != EM_NONE);
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (accept) char_r <= kle_translate(key_code[6:0], shift_r, caps_r);
  end

  // Line characters and the empty-line marker report cursor and length as zero.
  always_ff @(posedge clk) begin
    case (cw.emit)
      EM_STATUS: begin
        out_kind_r   <= KIND_STATUS;
        out_char_r   <= '0;
        out_cursor_r <= 7'(cursor_r);
        out_length_r <= 7'(length_r);
        out_rej_r    <= rej_r;
        out_last_r   <= 1'b1;
      end
      EM_CHAR: begin
        out_kind_r   <= KIND_CHAR;
        out_char_r   <= rdata_r;
        out_cursor_r <= '0;
        out_length_r <= '0;
        out_rej_r    <= 1'b0;
        out_last_r   <= !flags.ptr_not_last;
      end
      EM_EMPTY: begin
        out_kind_r   <= KIND_EMPTY;
        out_char_r   <= '0;
        out_cursor_r <= '0;
        out_length_r <= '0;
        out_rej_r    <= 1'b0;
        out_last_r   <= 1'b1;
      end
      default: begin
        out_kind_r <= out_kind_r;
      end
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_char_out = out_char_r;
  assign out_cursor   = out_cursor_r;
  assign out_length   = out_length_r;
  assign out_rejected = out_rej_r;
  assign out_last     = out_last_r;

  a_cur_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= length_r)
    else $error("cursor beyond end of line");

  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    length_r <= CAP_C)
    else $error("line length beyond capacity");

  a_rej_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rej_r |-> length_r == CAP_C)
    else $error("insert rejected while the store had room");

endmodule

[rtl/key_event_line_editor_top.sv]
// ----------------------------------------------------------------------------
// key_event_line_editor_top
// Keyboard event line editor with a microcoded sequencer over a line store.
// ----------------------------------------------------------------------------
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+------------------------------------------
//  input    | start high, busy low  | in_key_code, in_pressed
//  result   | out_valid, one cycle  | out_kind, out_char_out, out_cursor,
//           |                       | out_length, out_rejected, out_last
//
//  Busy stays high from acceptance through the final step of the item's
//  microprogram. Insert, backspace and delete need a read step and a write
//  step for each moved character; a backspace at the start of the line or a
//  delete at its end moves nothing. Enter takes one read step and one result
//  per character. Results are registered and appear in the cycle after their
//  step; the receiver cannot stall them. Reset is synchronous and active low;
//  it empties the line and needs no clearing pass, since entries beyond the
//  length are never used.
// ----------------------------------------------------------------------------
module key_event_line_editor_top #(
  parameter int CAPACITY = kle_pkg::KLE_CAPACITY
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_key_code,
  input  logic       in_pressed,
  output logic       out_valid,
  output logic [1:0] out_kind,
  output logic [6:0] out_char_out,
  output logic [6:0] out_cursor,
  output logic [6:0] out_length,
  output logic       out_rejected,
  output logic       out_last
);
  import kle_pkg::*;

  logic       accept;
  kle_cw_t    cw;
  kle_flags_t flags;

  assign accept = start && !busy;

  kle_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .key_code (in_key_code[6:0]),
    .pressed  (in_pressed),
    .flags    (flags),
    .cw       (cw),
    .busy     (busy)
  );

  kle_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .key_code     (in_key_code),
    .pressed      (in_pressed),
    .cw           (cw),
    .flags        (flags),
    .out_valid    (out_valid),
    .out_kind     (out_kind),
    .out_char_out (out_char_out),
    .out_cursor   (out_cursor),
    .out_length   (out_length),
    .out_rejected (out_rejected),
    .out_last     (out_last)
  );

endmodule

[bench/line_edit_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_edit_checker
// Watches both channels of the key event line editor, keeps its own copy of
// the line, cursor and modifier state, and compares every result with the
// oldest expected one, field by field.
// ----------------------------------------------------------------------------
module line_edit_checker #(
  parameter int CAPACITY = kle_pkg::KLE_CAPACITY
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic [7:0] in_key_code,
  input  logic       in_pressed,
  input  logic       out_valid,
  input  logic [1:0] out_kind,
  input  logic [6:0] out_char_out,
  input  logic [6:0] out_cursor,
  input  logic [6:0] out_length,
  input  logic       out_rejected,
  input  logic       out_last,
  output int         errors,
  output int         outstanding
);
  import kle_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] char_out;
    logic [6:0] cursor;
    logic [6:0] length;
    logic       rejected;
    logic       last;
  } editor_result_t;

  // Translation tables, entry 0 in the low bits.
  localparam logic [48:0] SYM_PLAIN     = {7'h60, 7'h2F, 7'h2E, 7'h2D, 7'h2C, 7'h3D, 7'h3B};
  localparam logic [48:0] SYM_SHIFTED   = {7'h7E, 7'h3F, 7'h3E, 7'h5F, 7'h3C, 7'h2B, 7'h3A};
  localparam logic [20:0] BRACE_SHIFTED = {7'h7D, 7'h7C, 7'h7B};
  localparam logic [69:0] DIGIT_SHIFTED = {7'h28, 7'h2A, 7'h26, 7'h5E, 7'h25,
                                           7'h24, 7'h23, 7'h40, 7'h21, 7'h29};

  editor_result_t due_results[$];
  logic [6:0]     line_chars[CAPACITY];
  int             cur_pos;
  int             line_len;
  logic           shift_on;
  logic           caps_lock;

  function automatic logic [6:0] typed_glyph(input logic [6:0] k, input logic sh,
                                             input logic cl);
    logic [6:0] g;
    int         idx;
    g = k;
    idx = int'(k);
    if (idx >= 58 && idx <= 64) begin
      g = sh ? SYM_SHIFTED[(idx - 58) * 7 +: 7] : SYM_PLAIN[(idx - 58) * 7 +: 7];
    end else if (idx == 94) begin
      g = sh ? 7'h22 : 7'h27;
    end else if (sh && idx >= 91 && idx <= 93) begin
      g = BRACE_SHIFTED[(idx - 91) * 7 +: 7];
    end else if (sh && idx >= 48 && idx <= 57) begin
      g = DIGIT_SHIFTED[(idx - 48) * 7 +: 7];
    end else if (idx >= 65 && idx <= 90 && !sh && !cl) begin
      g = k + 7'd32;
    end
    return g;
  endfunction

  function automatic editor_result_t make_result(input logic [1:0] kind, input logic [6:0] ch,
                                                 input logic rej, input logic last);
    editor_result_t r;
    r.kind     = kind;
    r.char_out = ch;
    r.cursor   = cur_pos[6:0];
    r.length   = line_len[6:0];
    r.rejected = rej;
    r.last     = last;
    return r;
  endfunction

  task automatic predict_key_event(input logic [7:0] code, input logic down);
    logic [6:0] k;
    logic       rej;
    int         n;
    int         i;
    k = code[6:0];
    rej = 1'b0;
    if (down) begin
      // A press looks at all eight bits and only touches the modifiers.
      if (code == KEY_SHIFT_DN) shift_on = 1'b1;
      if (code == KEY_CAPS_DN) caps_lock = ~caps_lock;
      due_results.push_back(make_result(KIND_STATUS, 7'd0, 1'b0, 1'b1));
    end else if (k == KEY_ENTER) begin
      n = line_len;
      cur_pos = 0;
      line_len = 0;
      if (n == 0) begin
        due_results.push_back(make_result(KIND_EMPTY, 7'd0, 1'b0, 1'b1));
      end else begin
        for (i = 0; i < n; i++) begin
          due_results.push_back(make_result(KIND_CHAR, line_chars[i], 1'b0, i == n - 1));
        end
      end
    end else begin
      case (k)
        KEY_ESC: begin
          cur_pos = 0;
          line_len = 0;
        end
        KEY_LEFT: if (cur_pos > 0) cur_pos--;
        KEY_RIGHT: if (cur_pos < line_len) cur_pos++;
        KEY_HOME: cur_pos = 0;
        KEY_END: cur_pos = line_len;
        KEY_BACKSPACE: begin
          if (cur_pos > 0) begin
            for (i = cur_pos - 1; i < line_len - 1; i++) line_chars[i] = line_chars[i + 1];
            cur_pos--;
            line_len--;
          end
        end
        KEY_DELETE: begin
          if (cur_pos < line_len) begin
            for (i = cur_pos; i < line_len - 1; i++) line_chars[i] = line_chars[i + 1];
            line_len--;
          end
        end
        KEY_SHIFT: shift_on = 1'b0;
        KEY_CTRL, KEY_CAPS, KEY_ARROW_UP, KEY_ARROW_DOWN, KEY_DEL_CHAR: ;
        default: begin
          if (line_len >= CAPACITY) begin
            rej = 1'b1;
          end else begin
            for (i = line_len; i > cur_pos; i--) line_chars[i] = line_chars[i - 1];
            line_chars[cur_pos] = typed_glyph(k, shift_on, caps_lock);
            cur_pos++;
            line_len++;
          end
        end
      endcase
      due_results.push_back(make_result(KIND_STATUS, 7'd0, rej, 1'b1));
    end
  endtask

  task automatic check_field(input string name, input logic [6:0] want, input logic [6:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    editor_result_t want;
    if (!rst_n) begin
      due_results.delete();
      cur_pos   = 0;
      line_len  = 0;
      shift_on  = 1'b0;
      caps_lock = 1'b0;
      errors    = 0;
    end else begin
      // Results are compared before the item accepted at this edge is
      // predicted, as anything on the result ports now belongs to older items.
      if (out_valid) begin
        if (due_results.size() == 0) begin
          $error("out_kind: no result expected, got %0d", out_kind);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("out_kind", {5'd0, want.kind}, {5'd0, out_kind});
          check_field("out_char_out", want.char_out, out_char_out);
          check_field("out_cursor", want.cursor, out_cursor);
          check_field("out_length", want.length, out_length);
          check_field("out_rejected", {6'd0, want.rejected}, {6'd0, out_rejected});
          check_field("out_last", {6'd0, want.last}, {6'd0, out_last});
        end
      end
      if (start && !busy) predict_key_event(in_key_code, in_pressed);
    end
    outstanding = due_results.size();
  end

endmodule

[bench/tb_key_event_line_editor_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_event_line_editor_top
// Drives key events into the line editor: a short directed run over every key
// class and translation, then random typing, editing, overfilled lines and
// noise under three sender idling patterns. The checker judges the results.
// ----------------------------------------------------------------------------
module tb_key_event_line_editor_top;
  import kle_pkg::*;

  localparam int CAPACITY     = KLE_CAPACITY;
  localparam int ITEM_TARGET  = 460;
  localparam int DRAIN_CYCLES = 160;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [7:0] in_key_code;
  logic       in_pressed;
  logic       out_valid;
  logic [1:0] out_kind;
  logic [6:0] out_char_out;
  logic [6:0] out_cursor;
  logic [6:0] out_length;
  logic       out_rejected;
  logic       out_last;
  int         errors;
  int         outstanding;
  int         items_sent;

  key_event_line_editor_top #(.CAPACITY(CAPACITY)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_key_code(in_key_code), .in_pressed(in_pressed),
    .out_valid(out_valid), .out_kind(out_kind), .out_char_out(out_char_out),
    .out_cursor(out_cursor), .out_length(out_length),
    .out_rejected(out_rejected), .out_last(out_last)
  );

  line_edit_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_key_code(in_key_code), .in_pressed(in_pressed),
    .out_valid(out_valid), .out_kind(out_kind), .out_char_out(out_char_out),
    .out_cursor(out_cursor), .out_length(out_length),
    .out_rejected(out_rejected), .out_last(out_last),
    .errors(errors), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_500_000;
    $display("tb_key_event_line_editor_top: errors");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with start still high, so back-to-back items need no gap.
  task automatic send_key(input logic [7:0] code, input logic down);
    int idle_pct;
    idle_pct = (items_sent < 150) ? 25 : (items_sent < 300) ? 88 : 0;
    while ($urandom_range(0, 99) < idle_pct) begin
      start       = 1'b0;
      in_key_code = 8'($urandom);
      in_pressed  = 1'($urandom);
      @(negedge clk);
    end
    start       = 1'b1;
    in_key_code = code;
    in_pressed  = down;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Releases mask the top bit away, so it is set at random on them.
  function automatic logic [7:0] release_code(input logic [6:0] k);
    logic hi;
    hi = 1'($urandom);
    return {hi, k};
  endfunction

  function automatic logic [6:0] edit_key();
    logic [6:0] k;
    case ($urandom_range(0, 5))
      0:       k = KEY_LEFT;
      1:       k = KEY_RIGHT;
      2:       k = KEY_HOME;
      3:       k = KEY_END;
      4:       k = KEY_BACKSPACE;
      default: k = KEY_DELETE;
    endcase
    return k;
  endfunction

  // Biased towards the translated ranges: symbols, quote, braces, digits and letters.
  function automatic logic [6:0] typed_key();
    logic [6:0] k;
    case ($urandom_range(0, 4))
      0:       k = 7'($urandom_range(48, 64));
      1:       k = 7'($urandom_range(91, 94));
      2:       k = 7'($urandom_range(65, 90));
      default: k = 7'($urandom_range(0, 127));
    endcase
    return k;
  endfunction

  task automatic type_burst();
    int n;
    n = $urandom_range(1, 12);
    repeat (n) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3: send_key(release_code(edit_key()), 1'b0);
        4:          send_key(KEY_SHIFT_DN, 1'b1);
        5:          send_key(release_code(KEY_SHIFT), 1'b0);
        6:          send_key(KEY_CAPS_DN, 1'b1);
        default:    send_key(release_code(typed_key()), 1'b0);
      endcase
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: send_key(release_code(KEY_ENTER), 1'b0);
      6:                send_key(release_code(KEY_ESC), 1'b0);
      default:          ;
    endcase
  endtask

  // Types past the capacity so that inserts are refused, then emits the line.
  task automatic fill_line();
    int n;
    send_key(release_code(KEY_ESC), 1'b0);
    for (n = 0; n < CAPACITY + 3; n++) begin
      if ($urandom_range(0, 7) == 0) send_key(release_code(edit_key()), 1'b0);
      send_key(release_code(typed_key()), 1'b0);
    end
    send_key(release_code(KEY_END), 1'b0);
    send_key(release_code(KEY_ENTER), 1'b0);
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 4)) send_key(8'($urandom), 1'($urandom));
  endtask

  initial begin : stimulus
    int pick;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_key_code = 8'd0;
    in_pressed  = 1'b0;
    items_sent  = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty enter, control code, both cases of a letter, every
    // shifted table, masking on release, caps, each edit key and two of the
    // ignored keys, then enter with a line.
    send_key({1'b0, KEY_ENTER}, 1'b0);
    send_key(8'd0, 1'b0);
    send_key(8'd65, 1'b0);
    send_key(KEY_SHIFT_DN, 1'b1);
    send_key(8'd65, 1'b0);
    send_key(8'd49, 1'b0);
    send_key(8'd91, 1'b0);
    send_key(8'd58, 1'b0);
    send_key(8'd94, 1'b0);
    send_key(8'd144, 1'b0);
    send_key(8'd58, 1'b0);
    send_key(8'd222, 1'b0);
    send_key(KEY_CAPS_DN, 1'b1);
    send_key(8'd90, 1'b0);
    send_key(8'd148, 1'b1);
    send_key(KEY_CAPS_DN, 1'b1);
    send_key({1'b0, KEY_LEFT}, 1'b0);
    send_key({1'b0, KEY_BACKSPACE}, 1'b0);
    send_key({1'b0, KEY_HOME}, 1'b0);
    send_key({1'b0, KEY_DELETE}, 1'b0);
    send_key({1'b0, KEY_RIGHT}, 1'b0);
    send_key({1'b0, KEY_END}, 1'b0);
    send_key({1'b0, KEY_CTRL}, 1'b0);
    send_key(8'd255, 1'b0);
    send_key(8'd255, 1'b1);
    send_key(8'd141, 1'b0);

    fill_line();
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        fill_line();
      end else if (pick < 78) begin
        type_burst();
      end else begin
        noise_burst();
      end
    end
    start = 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_key_event_line_editor_top: clean");
    end else begin
      $display("tb_key_event_line_editor_top: errors");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/kle_pkg.sv
rtl/kle_ucode_rom.sv
rtl/kle_seq.sv
rtl/kle_datapath.sv
rtl/key_event_line_editor_top.sv
bench/line_edit_checker.sv
bench/tb_key_event_line_editor_top.sv
